@@ hw/rtl/rfe_pkg.sv @@
// Shared types, constants and helpers for the response frame extractor.
// No dependencies; the other files, apart from rfe_if.sv, refer to it by scoped names.
`timescale 1ns / 1ps

package rfe_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_END_BYTE = 2'd1;
  localparam logic [1:0] REG_SERVICE_LOW = 2'd2;
  localparam logic [1:0] REG_SERVICE_HIGH = 2'd3;

  // Hunt phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_FRAME = 2'd2;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [3:0] service_low;
    logic [3:0] service_high;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Decode an ASCII hex digit; valid is low for any other byte.
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b0;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.valid = 1'b1;
      h.value = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      h.valid = 1'b1;
      h.value = b[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

@@ hw/rtl/rfe_if.sv @@
// Valid/ready channel interfaces for received bytes and frame bytes.
// Depends on nothing.
`timescale 1ns / 1ps

interface rfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

@@ hw/rtl/rfe_cfg_regs.sv @@
// APB-style configuration registers of the response frame extractor.
// Depends on rfe_pkg.
`timescale 1ns / 1ps

module rfe_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfe_pkg::PADDR_W-1:0] paddr,
  input  logic [rfe_pkg::PDATA_W-1:0] pwdata,
  output logic [rfe_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rfe_pkg::cfg_t               cfg
);

  rfe_pkg::cfg_t cfg_r;
  rfe_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        rfe_pkg::REG_START_BYTE:   cfg_nxt.start_byte = pwdata[7:0];
        rfe_pkg::REG_END_BYTE:     cfg_nxt.end_byte = pwdata[7:0];
        rfe_pkg::REG_SERVICE_LOW:  cfg_nxt.service_low = pwdata[3:0];
        rfe_pkg::REG_SERVICE_HIGH: cfg_nxt.service_high = pwdata[3:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= 8'd52;
      cfg_r.end_byte <= 8'd13;
      cfg_r.service_low <= 4'd1;
      cfg_r.service_high <= 4'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      rfe_pkg::REG_START_BYTE:   prdata[7:0] = cfg_r.start_byte;
      rfe_pkg::REG_END_BYTE:     prdata[7:0] = cfg_r.end_byte;
      rfe_pkg::REG_SERVICE_LOW:  prdata[3:0] = cfg_r.service_low;
      rfe_pkg::REG_SERVICE_HIGH: prdata[3:0] = cfg_r.service_high;
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/response_frame_extractor.sv @@
// Response frame extractor: one received byte per cycle is written into the frame store
// while no drain runs. A closing byte starts a drain: the drain flag is registered, then
// the single read port of the store reads the frame bytes one at a time into the output
// register, holding while the output stalls. Input requests wait while a drain runs.
// Reset (synchronous, active low) clears phase, counts and output valid and restores the
// register defaults; store contents stay undefined, with no clearing pass.
`timescale 1ns / 1ps

module response_frame_extractor (
  input  logic                        clk,
  input  logic                        rst_n,
  rfe_in_if.sink                      in_ch,
  rfe_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfe_pkg::PADDR_W-1:0] paddr,
  input  logic [rfe_pkg::PDATA_W-1:0] pwdata,
  output logic [rfe_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW = rfe_pkg::ADDR_W;
  localparam int CW = rfe_pkg::CNT_W;

  rfe_pkg::cfg_t cfg;

  rfe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [7:0]    frame_store_r [rfe_pkg::BUFFER_DEPTH];

  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] held_count_r, held_count_nxt;
  logic [AW-1:0] frame_start_r, frame_start_nxt;
  logic          drain_r, drain_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] end_ptr_r, end_ptr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          in_fire;
  logic          full;
  logic [AW-1:0] wr_addr;
  logic [7:0]    b;
  rfe_pkg::hex_t hex;
  logic          service_ok;
  logic          closes;
  logic          rd_en;
  logic          rd_last;

  assign in_ch.ready = !drain_r;
  assign in_fire = in_ch.valid && !drain_r;
  assign b = in_ch.rx_byte;

  // A full store drops everything held; the new byte opens a fresh store.
  assign full = (held_count_r >= CW'(rfe_pkg::BUFFER_DEPTH));
  assign wr_addr = full ? '0 : held_count_r[AW-1:0];

  assign hex = rfe_pkg::hex_decode(b);
  assign service_ok = hex.valid && (hex.value >= cfg.service_low)
                      && (hex.value <= cfg.service_high);

  assign rd_en = drain_r && (!out_valid_r || out_ch.ready);
  assign rd_last = (rd_ptr_r == end_ptr_r);

  always_comb begin
    phase_nxt = phase_r;
    held_count_nxt = held_count_r;
    frame_start_nxt = frame_start_r;
    drain_nxt = drain_r;
    rd_ptr_nxt = rd_ptr_r;
    end_ptr_nxt = end_ptr_r;
    closes = 1'b0;

    if (in_fire) begin
      held_count_nxt = CW'(wr_addr) + CW'(1);
      if (!full && phase_r == rfe_pkg::PH_FRAME) begin
        closes = (b == cfg.end_byte);
      end else if (!full && phase_r == rfe_pkg::PH_START && service_ok) begin
        phase_nxt = rfe_pkg::PH_FRAME;
        frame_start_nxt = wr_addr - AW'(1);
        closes = (b == cfg.end_byte);
      end else begin
        phase_nxt = (b == cfg.start_byte) ? rfe_pkg::PH_START : rfe_pkg::PH_HUNT;
      end

      if (closes) begin
        drain_nxt = 1'b1;
        rd_ptr_nxt = frame_start_nxt;
        end_ptr_nxt = wr_addr;
        phase_nxt = rfe_pkg::PH_HUNT;
        held_count_nxt = '0;
      end
    end

    // advance the drain one store read at a time
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + AW'(1);
      if (rd_last) begin
        drain_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (rd_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rfe_pkg::PH_HUNT;
      held_count_r <= '0;
      drain_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_count_r <= held_count_nxt;
      drain_r <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_start_r <= frame_start_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    end_ptr_r <= end_ptr_nxt;
  end

  // Frame store: one write port for received bytes, one registered read port for the drain.
  // The read register doubles as the output payload; hold it while the output stalls.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_store_r[wr_addr] <= b;
    end
    if (rd_en) begin
      out_byte_r <= frame_store_r[rd_ptr_r];
      out_last_r <= rd_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.frame_last = out_last_r;

endmodule

@@ bench/rfe_tb_pkg.sv @@
// Frame checker class for the response frame extractor bench: predicts frame bytes
// from accepted requests and compares them with the beats the block delivers.
// Depends on rfe_pkg for register indexes, phase codes and the register struct.
`timescale 1ns / 1ps

package rfe_tb_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  class frame_checker;
    rfe_pkg::cfg_t regs;
    logic [1:0]    phase;
    int unsigned   held;
    int unsigned   span;
    logic [7:0]    store [rfe_pkg::BUFFER_DEPTH];
    frame_beat_t   beats_due[$];
    int            errors;

    function new();
      regs.start_byte   = 8'h34;
      regs.end_byte     = 8'h0d;
      regs.service_low  = 4'd1;
      regs.service_high = 4'd10;
      errors            = 0;
      drop_held();
    endfunction

    function void drop_held();
      phase = rfe_pkg::PH_HUNT;
      held  = 0;
      span  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        rfe_pkg::REG_START_BYTE:   regs.start_byte = value[7:0];
        rfe_pkg::REG_END_BYTE:     regs.end_byte = value[7:0];
        rfe_pkg::REG_SERVICE_LOW:  regs.service_low = value[3:0];
        rfe_pkg::REG_SERVICE_HIGH: regs.service_high = value[3:0];
        default: ;
      endcase
    endfunction

    function bit service_ok(logic [7:0] b);
      int v;
      v = -1;
      if (b >= 8'h30 && b <= 8'h39) v = int'(b) - 'h30;
      else if (b >= 8'h41 && b <= 8'h46) v = int'(b) - 'h41 + 10;
      else if (b >= 8'h61 && b <= 8'h66) v = int'(b) - 'h61 + 10;
      return v >= 0 && v >= int'(regs.service_low) && v <= int'(regs.service_high);
    endfunction

    // Advance the hunt on one accepted request and queue any completed frame.
    function void note_request(logic [7:0] b);
      bit          closes;
      frame_beat_t beat;
      closes = 1'b0;
      if (held >= rfe_pkg::BUFFER_DEPTH) drop_held();
      store[held % rfe_pkg::BUFFER_DEPTH] = b;
      held++;
      if (phase == rfe_pkg::PH_FRAME) begin
        span++;
        closes = (b == regs.end_byte);
      end else if (phase == rfe_pkg::PH_START && service_ok(b)) begin
        phase  = rfe_pkg::PH_FRAME;
        span   = 2;
        closes = (b == regs.end_byte);
      end else begin
        phase = (b == regs.start_byte) ? rfe_pkg::PH_START : rfe_pkg::PH_HUNT;
        span  = 0;
      end
      if (closes) begin
        for (int unsigned k = held - span; k < held; k++) begin
          beat.data = store[k % rfe_pkg::BUFFER_DEPTH];
          beat.last = (k + 1 == held);
          beats_due.push_back(beat);
        end
        drop_held();
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    task report(string what);
      $display("%0t: %s", $time, what);
      errors++;
    endtask

    task check_beat(logic [7:0] data, logic last);
      frame_beat_t want;
      if (beats_due.size() == 0) begin
        report($sformatf("unexpected frame byte %02h last %0b", data, last));
      end else begin
        want = beats_due.pop_front();
        if (data !== want.data)
          report($sformatf("frame_byte %02h, expected %02h", data, want.data));
        if (last !== want.last)
          report($sformatf("frame_last %0b on byte %02h, expected %0b", last, data, want.last));
      end
    endtask
  endclass

endpackage

@@ bench/response_frame_extractor_tb.sv @@
// Bench top for the response frame extractor: directed and random byte streams under
// several register settings, random gaps on both channels, checked by frame_checker.
// Depends on rfe_pkg, the channel interfaces and rfe_tb_pkg.
`timescale 1ns / 1ps

module response_frame_extractor_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_SLACK = 8;
  localparam int TAIL_CYCLES = 20;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rfe_pkg::PADDR_W-1:0] paddr;
  logic [rfe_pkg::PDATA_W-1:0] pwdata;
  logic [rfe_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  rfe_in_if  in_ch ();
  rfe_out_if out_ch ();

  rfe_tb_pkg::frame_checker sb;
  bit           in_quiet;
  bit           out_quiet;
  int           sent;
  int           idle_cycles;

  response_frame_extractor i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Flip between bursts with no gaps and stretches of randomly drawn gaps.
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 11) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 15));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) sb.check_beat(out_ch.frame_byte, out_ch.frame_last);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("response_frame_extractor_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int w;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = draw_wait(out_quiet);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Hold off until every frame byte is out and the block has gone quiet.
  task settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task configure(input logic [7:0] start_b, input logic [7:0] end_b,
                 input logic [3:0] lo, input logic [3:0] hi);
    settle();
    write_reg(rfe_pkg::REG_START_BYTE, 32'(start_b));
    write_reg(rfe_pkg::REG_END_BYTE, 32'(end_b));
    write_reg(rfe_pkg::REG_SERVICE_LOW, 32'(lo));
    write_reg(rfe_pkg::REG_SERVICE_HIGH, 32'(hi));
  endtask

  function automatic logic [7:0] service_digit();
    int v;
    if (sb.regs.service_low <= sb.regs.service_high)
      v = $urandom_range(sb.regs.service_low, sb.regs.service_high);
    else
      v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] non_service_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (sb.service_ok(b));
    return b;
  endfunction

  // Keep the end byte out of a frame body so the frame runs its full length.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == sb.regs.end_byte) ? ~b : b;
  endfunction

  task send_frame(input int body_n);
    send_byte(sb.regs.start_byte);
    send_byte(service_digit());
    repeat (body_n) send_byte(body_byte());
    send_byte(sb.regs.end_byte);
  endtask

  task run_random(input int n_items, input bit with_overflow);
    int stop_at;
    stop_at = sent + n_items;
    // Run past the store depth so held bytes get dropped mid-frame.
    if (with_overflow) send_frame($urandom_range(rfe_pkg::BUFFER_DEPTH - 2,
                                                  rfe_pkg::BUFFER_DEPTH + 6));
    while (sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
          send_frame($urandom_range(0, 8));
        end
        6, 7: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        8: begin
          send_byte(sb.regs.start_byte);
          if ($urandom_range(0, 1)) begin
            send_byte(non_service_byte());
          end else begin
            send_byte(service_digit());
            repeat ($urandom_range(1, 5)) send_byte(body_byte());
          end
        end
        default: begin
          repeat ($urandom_range(1, 3)) send_byte(sb.regs.start_byte);
          send_frame($urandom_range(0, 4));
        end
      endcase
    end
  endtask

  initial begin
    logic [3:0] lo;
    sb          = new();
    sent        = 0;
    idle_cycles = 0;
    in_quiet    = 1'b0;
    out_quiet   = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: start '4', end CR, service digits 1 to 10.
    send_byte(8'h34); send_byte("1"); send_byte(8'h00); send_byte(8'hff); send_byte(8'h0d);
    send_byte(8'h34); send_byte("A"); send_byte(8'h0d);
    // Digits below and above the range, two non-hex bytes, then a lowercase digit.
    send_byte(8'h34); send_byte("0"); send_byte(8'h34); send_byte("B");
    send_byte(8'h34); send_byte("G"); send_byte(8'h34); send_byte(8'h00);
    send_byte(8'h34); send_byte("a"); send_byte(8'h0d);
    // The start byte itself is a digit in range.
    send_byte(8'h34); send_byte(8'h34); send_byte(8'h0d);

    configure(8'h00, 8'hff, 4'd0, 4'd15);
    send_byte(8'h00); send_byte("0"); send_byte(8'hff);
    send_byte(8'h00); send_byte("f"); send_byte(8'hff);
    run_random(40, 1'b1);

    configure(8'hff, 8'h00, 4'd15, 4'd15);
    send_byte(8'hff); send_byte("F"); send_byte(8'h00);
    run_random(20, 1'b0);

    // End byte doubles as a service digit: two-byte frame.
    configure(8'h34, "7", 4'd5, 4'd9);
    send_byte(8'h34); send_byte("7");
    run_random(20, 1'b0);

    // Empty service range: nothing may open.
    configure(8'h34, 8'h0d, 4'd9, 4'd2);
    send_byte(8'h34); send_byte("5"); send_byte(8'h0d);
    run_random(15, 1'b0);

    repeat (2) begin
      lo = 4'($urandom_range(0, 15));
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), lo,
                4'($urandom_range(lo, 15)));
      run_random(15, 1'b0);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d frame bytes never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("response_frame_extractor_tb: clean");
    end else begin
      $display("response_frame_extractor_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rfe_pkg.sv
hw/rtl/rfe_if.sv
hw/rtl/rfe_cfg_regs.sv
hw/rtl/response_frame_extractor.sv
bench/rfe_tb_pkg.sv
bench/response_frame_extractor_tb.sv
